// ===== rtl/rbrv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrv_pkg: shared constants and types for the range/bearing visibility core
// Angle table, widths and the stage record passed from front to back.
// ----------------------------------------------------------------------------
package rbrv_pkg;
   localparam int COORD_WIDTH     = 24;
   localparam int ANGLE_FRAC_BITS = 4;
   localparam int DIFF_W   = COORD_WIDTH + 1;
   localparam int CORDIC_STEPS = 24;
   localparam int PRESCALE = 24;
   localparam int CW       = DIFF_W + PRESCALE + 3;  // CORDIC x/y width
   localparam int ZW       = 24;                     // angle table width; accumulator is ZW+1
   localparam int ACC_FRAC = 16;
   localparam int SQ_W     = 2 * DIFF_W + 2;         // radicand width
   localparam int RT_W     = SQ_W / 2;               // root width
   localparam int RANGE_W  = 25;
   localparam int ANG_W    = 13;
   localparam int TAG_W    = 16;
   localparam int HEAD_W   = 13;
   localparam int MAXD_W   = 24;
   localparam int VIEW_W   = 9;
   localparam int CFG_IDX_W = 1;
   localparam int CFG_DAT_W = 24;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_VIEW_ANGLE   = 1'd1;
   localparam logic signed [15:0] HALF    = 16'sd180 <<< ANGLE_FRAC_BITS;
   localparam logic signed [15:0] FULL    = 16'sd360 <<< ANGLE_FRAC_BITS;
   localparam logic signed [15:0] QUARTER = 16'sd90  <<< ANGLE_FRAC_BITS;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   function automatic logic [ZW-1:0] atan_entry(input int i);
      logic [ZW-1:0] t;
      begin
         unique case (i)
            0: t = 24'd2949120;  1: t = 24'd1740967;  2: t = 24'd919879;
            3: t = 24'd475137;   4: t = 24'd234379;   5: t = 24'd117304;
            6: t = 24'd58666;    7: t = 24'd29335;    8: t = 24'd14668;
            9: t = 24'd7334;     10: t = 24'd3667;    11: t = 24'd1833;
            12: t = 24'd917;     13: t = 24'd458;     14: t = 24'd229;
            15: t = 24'd115;     16: t = 24'd57;      17: t = 24'd29;
            18: t = 24'd14;      19: t = 24'd7;       20: t = 24'd4;
            21: t = 24'd2;       22: t = 24'd1;       default: t = 24'd0;
         endcase
         return t;
      end
   endfunction

   typedef struct packed {
      logic [DIFF_W-1:0] ax;
      logic [DIFF_W-1:0] ay;
      logic              dx_neg;
      logic              dy_neg;
      logic [HEAD_W-1:0] heading;
      logic [TAG_W-1:0]  tag;
   } item_type;
endpackage

// ===== rtl/rbrv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrv_front: input stage
// Takes a pose pair, forms folded differences and a reduced heading.
// ----------------------------------------------------------------------------
module rbrv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_det_x,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_det_y,
   input  logic [rbrv_pkg::HEAD_W-1:0] req_det_heading,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_mark_x,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_mark_y,
   input  logic [rbrv_pkg::TAG_W-1:0] req_pair_tag,
   output logic                q_valid,
   input  logic                q_take,
   output rbrv_pkg::item_type  q_item
);
   import rbrv_pkg::*;
   item_type mem_ff [QDEPTH];
   logic [QPTR_W:0] wp_ff, wp_in, rp_ff, rp_in;
   logic signed [DIFF_W-1:0] dx, dy;
   item_type it;
   logic push;

   assign req_stall = (wp_ff - rp_ff) == (QPTR_W+1)'(QDEPTH);
   assign push = req_valid && !req_stall;
   assign q_valid = wp_ff != rp_ff;
   assign q_item = mem_ff[rp_ff[QPTR_W-1:0]];

   always_comb begin
      dx = DIFF_W'(req_mark_x) - DIFF_W'(req_det_x);
      dy = DIFF_W'(req_mark_y) - DIFF_W'(req_det_y);
      it.ax = dx[DIFF_W-1] ? -dx : dx;
      it.ay = dy[DIFF_W-1] ? -dy : dy;
      it.dx_neg = dx[DIFF_W-1];
      it.dy_neg = dy[DIFF_W-1];
      it.heading = (req_det_heading >= HEAD_W'(FULL)) ? req_det_heading - HEAD_W'(FULL)
                                                        : req_det_heading;
      it.tag = req_pair_tag;
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = (q_valid && q_take) ? rp_ff + 1'b1 : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff[QPTR_W-1:0]] <= it;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule

// ===== rtl/rbrv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrv_back: compute pipeline
// Squares, CORDIC vectoring and a bit-pair root in lockstep stages, then
// unfolds, wraps and checks the field of view. Advances as one pipeline.
// ----------------------------------------------------------------------------
module rbrv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_take,
   input  rbrv_pkg::item_type  q_item,
   input  logic [rbrv_pkg::MAXD_W-1:0] max_distance,
   input  logic [rbrv_pkg::VIEW_W-1:0] view_angle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [rbrv_pkg::TAG_W-1:0] rsp_result_tag,
   output logic                rsp_visible,
   output logic signed [rbrv_pkg::ANG_W-1:0] rsp_rel_bearing,
   output logic [rbrv_pkg::RANGE_W-1:0] rsp_range
);
   import rbrv_pkg::*;
   localparam int NS = CORDIC_STEPS;
   localparam int RS = RT_W;            // root iterations
   localparam int NP = (NS > RS) ? NS : RS;

   logic adv;
   // stage 0: square
   logic v0_ff;
   item_type i0_ff;
   logic [SQ_W-1:0] s0_ff;
   // cordic/root chain
   logic v_ff [NP+1];
   item_type it_ff [NP+1];
   logic signed [CW-1:0] x_ff [NP+1], y_ff [NP+1];
   logic signed [ZW:0] z_ff [NP+1];
   logic [SQ_W-1:0] rem_ff [NP+1];
   logic [RT_W-1:0] r_ff [NP+1];
   // output
   logic vo_ff;
   logic [TAG_W-1:0] tag_ff;
   logic vis_ff;
   logic signed [ANG_W-1:0] rel_ff;
   logic [RANGE_W-1:0] rng_ff;

   logic signed [CW-1:0] xn [NP], yn [NP];
   logic signed [ZW:0] zn [NP];
   logic [SQ_W-1:0] remn [NP];
   logic [RT_W-1:0] rn [NP];

   assign adv = !(vo_ff && rsp_stall);
   assign q_take = adv;

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         logic [RT_W+1:0] trial;
         logic [SQ_W-1:0] part;
         trial = '0;
         part  = '0;
         if (i < NS) begin
            if (!y_ff[i][CW-1]) begin
               xn[i] = x_ff[i] + (y_ff[i] >>> i);
               yn[i] = y_ff[i] - (x_ff[i] >>> i);
               zn[i] = z_ff[i] + (ZW+1)'(atan_entry(i));
            end else begin
               xn[i] = x_ff[i] - (y_ff[i] >>> i);
               yn[i] = y_ff[i] + (x_ff[i] >>> i);
               zn[i] = z_ff[i] - (ZW+1)'(atan_entry(i));
            end
         end else begin
            xn[i] = x_ff[i];
            yn[i] = y_ff[i];
            zn[i] = z_ff[i];
         end
         if (i < RS) begin
            part  = rem_ff[i] >> (2 * (RS - 1 - i));
            trial = {r_ff[i], 2'b01};
            if (SQ_W'(part) >= SQ_W'(trial)) begin
               remn[i] = rem_ff[i] - (SQ_W'(trial) << (2 * (RS - 1 - i)));
               rn[i] = {r_ff[i][RT_W-2:0], 1'b1};
            end else begin
               remn[i] = rem_ff[i];
               rn[i] = {r_ff[i][RT_W-2:0], 1'b0};
            end
         end else begin
            remn[i] = rem_ff[i];
            rn[i] = r_ff[i];
         end
      end
   end

   // final stage
   logic signed [ZW:0] zc;
   logic signed [15:0] phi, bear, rel, mag;
   logic [RT_W-1:0] rt;
   logic [RANGE_W-1:0] rng;
   item_type fi;
   always_comb begin
      fi = it_ff[NP];
      zc = z_ff[NP][ZW] ? '0 : z_ff[NP];
      if (fi.ay == '0) phi = '0;
      else if (fi.ax == '0) phi = QUARTER;
      else phi = 16'(( zc + (ZW+1)'(1 << (ACC_FRAC-ANGLE_FRAC_BITS-1)))
                     >>> (ACC_FRAC-ANGLE_FRAC_BITS));
      if (fi.ax == '0 && fi.ay == '0) bear = '0;
      else if (!fi.dx_neg) bear = fi.dy_neg ? -phi : phi;
      else bear = fi.dy_neg ? phi - HALF : HALF - phi;
      rel = bear - 16'(fi.heading);
      if (rel > HALF) rel = rel - FULL;
      else if (rel < -HALF) rel = rel + FULL;
      mag = rel[15] ? -rel : rel;
      rt = r_ff[NP];
      rng = (rt > RT_W'(33554431)) ? RANGE_W'(33554431) : RANGE_W'(rt);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i0_ff <= q_item;
         s0_ff <= SQ_W'(q_item.ax) * SQ_W'(q_item.ax) + SQ_W'(q_item.ay) * SQ_W'(q_item.ay);
         it_ff[0] <= i0_ff;
         x_ff[0] <= CW'(i0_ff.ax) <<< PRESCALE;
         y_ff[0] <= CW'(i0_ff.ay) <<< PRESCALE;
         z_ff[0] <= '0;
         rem_ff[0] <= s0_ff;
         r_ff[0] <= '0;
         for (int i = 0; i < NP; i++) begin
            it_ff[i+1] <= it_ff[i];
            x_ff[i+1] <= xn[i];
            y_ff[i+1] <= yn[i];
            z_ff[i+1] <= zn[i];
            rem_ff[i+1] <= remn[i];
            r_ff[i+1] <= rn[i];
         end
         tag_ff <= fi.tag;
         rel_ff <= ANG_W'(rel);
         rng_ff <= rng;
         vis_ff <= (rng < RANGE_W'(max_distance)) &&
                   ((mag >>> ANGLE_FRAC_BITS) < 16'(view_angle >> 1));
      end
      if (reset) begin
         v0_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int i = 0; i <= NP; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v0_ff <= q_valid;
         v_ff[0] <= v0_ff;
         for (int i = 0; i < NP; i++) v_ff[i+1] <= v_ff[i];
         vo_ff <= v_ff[NP];
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_result_tag = tag_ff;
   assign rsp_visible = vis_ff;
   assign rsp_rel_bearing = rel_ff;
   assign rsp_range = rng_ff;
endmodule

// ===== rtl/relative_bearing_range_visibility_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_bearing_range_visibility_core: range, bearing and view check
// Usage: present a detector pose and a marker position with req_valid; a
// beat is taken when req_stall is low. Each beat yields one rsp_ beat with
// the tag, range, relative bearing and visible flag.
// Throughput: one beat per cycle while rsp_stall is low, set by the fully
// pipelined CORDIC and root stages. Path from the accepting edge to rsp_valid
// with the queue empty: queue read into the squarer, CORDIC load, 26 root/CORDIC
// stages, output register.
// A four-entry queue parts the input stage from the pipeline; when rsp_stall
// is high with a response held the whole pipeline holds and the queue fills, then req_stall rises.
// Write csr_ registers only while idle. Synchronous reset empties the queue
// and pipeline and sets max_distance to 1220 and view_angle to 60.
// ----------------------------------------------------------------------------
module relative_bearing_range_visibility_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_det_x,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_det_y,
   input  logic [rbrv_pkg::HEAD_W-1:0] req_det_heading,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_mark_x,
   input  logic signed [rbrv_pkg::COORD_WIDTH-1:0] req_mark_y,
   input  logic [rbrv_pkg::TAG_W-1:0] req_pair_tag,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [rbrv_pkg::TAG_W-1:0] rsp_result_tag,
   output logic rsp_visible,
   output logic signed [rbrv_pkg::ANG_W-1:0] rsp_rel_bearing,
   output logic [rbrv_pkg::RANGE_W-1:0] rsp_range,
   input  logic csr_write,
   input  logic [rbrv_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [rbrv_pkg::CFG_DAT_W-1:0] csr_data
);
   import rbrv_pkg::*;
   logic [MAXD_W-1:0] maxd_ff;
   logic [VIEW_W-1:0] view_ff;
   logic q_valid, q_take;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxd_ff <= MAXD_W'(1220);
         view_ff <= VIEW_W'(60);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MAX_DISTANCE: maxd_ff <= csr_data[MAXD_W-1:0];
            REG_VIEW_ANGLE:   view_ff <= csr_data[VIEW_W-1:0];
            default: ;
         endcase
      end
   end

   rbrv_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_det_x, .req_det_y,
      .req_det_heading, .req_mark_x, .req_mark_y, .req_pair_tag,
      .q_valid, .q_take, .q_item
   );

   rbrv_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_item,
      .max_distance(maxd_ff), .view_angle(view_ff),
      .rsp_valid, .rsp_stall, .rsp_result_tag, .rsp_visible,
      .rsp_rel_bearing, .rsp_range
   );
endmodule
